// ===== src/fppd_pkg.sv =====
package fppd_pkg;

	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 24;
	localparam int RUN_W = 4;
	localparam int JOB_W = 8;
	localparam int MASK_W = 8;
	localparam int TIME_W = 8;

	typedef struct packed {
		logic [TIME_W-1:0] offset;
		logic [TIME_W-1:0] runlen;
		logic [TIME_W-1:0] period;
	} timing_t;

	typedef struct packed {
		logic [RUN_W-1:0]  running_task;
		logic              job_started;
		logic [JOB_W-1:0]  job_number;
		logic [MASK_W-1:0] ready_mask;
	} result_t;

	localparam logic [CFG_W-1:0] TIMING_RESET [CFG_COUNT] = '{
		24'h000414, 24'h050114, 24'h05021E, 24'h05011E,
		24'h0A0132, 24'h0A0132, 24'h190232, 24'h190232
	};

endpackage

// ===== src/fppd_cfg_regs.sv =====
module fppd_cfg_regs
	import fppd_pkg::*;
#(
	parameter int NUM_TASKS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	output timing_t [NUM_TASKS-1:0]        timing
);

	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_task
		if (i < CFG_COUNT) begin : g_reg
			timing_t timing_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					timing_q <= timing_t'(TIMING_RESET[i]);
				end else if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
					timing_q <= timing_t'(cfg_data);
				end
			end

			assign timing[i] = timing_q;
		end else begin : g_none
			// Tasks without a register have period zero and never become ready.
			assign timing[i] = '0;
		end
	end

endmodule

// ===== src/fppd_core.sv =====
module fppd_core
	import fppd_pkg::*;
#(
	parameter int NUM_TASKS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    tick,
	input  timing_t [NUM_TASKS-1:0] timing,
	output result_t                 result
);

	localparam int AW = $clog2(NUM_TASKS + 1);
	localparam int IW = $clog2(NUM_TASKS);
	localparam logic [AW-1:0] IDLE = AW'(NUM_TASKS);

	logic [TIME_W-1:0] phase_q [NUM_TASKS];
	logic [TIME_W-1:0] phase_n [NUM_TASKS];
	logic [JOB_W-1:0]  jobs_q  [NUM_TASKS];
	logic [JOB_W-1:0]  jobs_n  [NUM_TASKS];
	logic [NUM_TASKS-1:0] done_q, done_n, ready;
	logic [AW-1:0]     active_q, active_n;
	logic [TIME_W-1:0] elapsed_q, elapsed_n;
	logic [IW-1:0]     pick;
	logic              started;
	logic [AW+RUN_W-1:0] active_wide;

	always_comb begin
		pick = '0;
		for (int i = NUM_TASKS - 1; i >= 0; i--) begin
			if (ready[i]) begin
				pick = IW'(i);
			end
		end
	end

	always_comb begin
		logic [TIME_W:0]   nxt;
		logic [TIME_W-1:0] el;
		phase_n   = phase_q;
		jobs_n    = jobs_q;
		done_n    = done_q;
		active_n  = active_q;
		elapsed_n = elapsed_q;
		started   = 1'b0;
		nxt       = '0;
		el        = '0;
		if (tick) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				nxt = {1'b0, phase_q[i]} + 1'b1;
				phase_n[i] = (nxt >= {1'b0, timing[i].period}) ? '0 : nxt[TIME_W-1:0];
			end
			if (active_q != IDLE) begin
				el = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
				if (el >= timing[active_q[IW-1:0]].runlen) begin
					done_n[active_q[IW-1:0]] = 1'b1;
					active_n  = IDLE;
					elapsed_n = '0;
				end else begin
					elapsed_n = el;
				end
			end
			for (int i = 0; i < NUM_TASKS; i++) begin
				if (phase_n[i] == '0) begin
					done_n[i] = 1'b0;
				end
			end
		end
		for (int i = 0; i < NUM_TASKS; i++) begin
			ready[i] = (phase_n[i] > timing[i].offset) && !done_n[i];
		end
		if (tick && active_n == IDLE && (|ready)) begin
			active_n     = AW'(pick);
			elapsed_n    = '0;
			jobs_n[pick] = jobs_q[pick] + 1'b1;
			started      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				phase_q[i] <= '0;
				jobs_q[i]  <= '0;
			end
			done_q    <= '0;
			active_q  <= IDLE;
			elapsed_q <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			jobs_q    <= jobs_n;
			done_q    <= done_n;
			active_q  <= active_n;
			elapsed_q <= elapsed_n;
		end
	end

	assign active_wide = {{RUN_W{1'b0}}, active_n};

	always_comb begin
		result.running_task = active_wide[RUN_W-1:0];
		result.job_started  = started;
		result.job_number   = (active_n != IDLE) ? jobs_n[active_n[IW-1:0]] : '0;
		result.ready_mask   = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < NUM_TASKS) begin
				result.ready_mask[i] = ready[i];
			end
		end
	end

endmodule

// ===== src/fixed_priority_periodic_dispatcher_unit.sv =====
// Non-preemptive fixed-priority dispatcher for periodic tasks. Each input beat
// is one time tick (tick_marker = 1) or a status query (tick_marker = 0), and
// each input beat yields exactly one output beat with the running task (the
// task count means idle), whether a job started, its job number and the mask
// of ready tasks. The block takes one beat per cycle while in_stall is low; a
// beat passes an input register and then the result register, moving on when
// the result register is free or out_stall is low. The task state is updated
// by combinational logic as the beat leaves the input register. The user must
// write timing registers through the cfg port only while no beat is in flight;
// the block itself does not enforce this.
module fixed_priority_periodic_dispatcher_unit
	import fppd_pkg::*;
#(
	parameter int NUM_TASKS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 tick_marker,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [RUN_W-1:0]     running_task,
	output logic                 job_started,
	output logic [JOB_W-1:0]     job_number,
	output logic [MASK_W-1:0]    ready_mask
);

	timing_t [NUM_TASKS-1:0] timing;
	result_t result, result_s2;
	logic    valid_s1, tick_s1, valid_s2, advance;

	fppd_cfg_regs #(.NUM_TASKS(NUM_TASKS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	fppd_core #(.NUM_TASKS(NUM_TASKS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.timing (timing),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || !out_stall) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1 <= tick_marker;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign running_task = result_s2.running_task;
	assign job_started  = result_s2.job_started;
	assign job_number   = result_s2.job_number;
	assign ready_mask   = result_s2.ready_mask;

endmodule
